@@ design/ogru_pkg.sv @@
`timescale 1ns / 1ps
package ogru_pkg;

  // opcodes carried in s_axis_tuser
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_POSE  = 3'd3;
  localparam logic [2:0] OP_RAY   = 3'd4;

  // result kinds carried in m_axis_tuser
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // done status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OFF_MAP = 2'd1;
  localparam logic [1:0] ST_SAME    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CELL_SIZE  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_COL = 3'd1;
  localparam logic [2:0] REG_ORIGIN_ROW = 3'd2;
  localparam logic [2:0] REG_UNKNOWN    = 3'd3;
  localparam logic [2:0] REG_FREE       = 3'd4;
  localparam logic [2:0] REG_ROBOT      = 3'd5;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int SIZE_W      = 12;
  localparam int ORIGIN_W    = 5;
  localparam int CODE_W      = 8;
  localparam int MM_W        = 16;
  localparam int OUT_COORD_W = 5;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 24;

  // mm to cell conversion: numerator 2|mm|+size and quotient, cell coordinate, ray error term
  localparam int NUM_W   = 17;
  localparam int COORD_W = 19;
  localparam int ERR_W   = 20;

  localparam logic [SIZE_W-1:0]   SIZE_RST     = 12'd50;
  localparam logic [ORIGIN_W-1:0] ORIGIN_RST   = 5'd16;
  localparam logic [CODE_W-1:0]   UNKNOWN_RST  = 8'hFF;
  localparam logic [CODE_W-1:0]   FREE_RST     = 8'h00;
  localparam logic [CODE_W-1:0]   ROBOT_RST    = 8'h02;

endpackage

@@ design/occupancy_grid_ray_update_core.sv @@
`timescale 1ns / 1ps
// channel   | dir | handshake               | tuser      | tdata / other
// s_axis    | in  | s_axis_tvalid/tready    | opcode     | positions, cell, write value
// m_axis    | out | m_axis_tvalid/tready    | kind       | col, row, value, status; tlast
// cfg       | in  | cfg_we_i (no wait)      | -          | cfg_idx_i, cfg_data_i
//
// one operation at a time; the cell store is a 1024 x 8 memory with a registered read.
// clear sweeps the store one cell per cycle, then returns a done transfer.
// each mm to cell conversion runs a restoring divider; pose needs two, ray four.
// ray trace then steps one cell per cycle while the output register can take a result.
// after reset the same sweep fills the store with the reset unknown code before s_axis_tready rises.
// a full output register with m_axis_tready low holds the sequencer at the next transfer.
module occupancy_grid_ray_update_core #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // start_x[15:0] start_y[31:16] end_x[47:32] end_y[63:48]
  // cell_col[79:64] cell_row[95:80] write_value[103:96]
  input  logic [ogru_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [2:0]                        s_axis_tuser,   // opcode[2:0]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // out_col[4:0] out_row[9:5] out_value[17:10] status[19:18] zero[23:20]
  output logic [ogru_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,   // kind[0]
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [ogru_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ogru_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ogru_pkg::*;

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT);
  localparam int CNT_W = $clog2(NUM_W);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_RD2    = 4'd3;
  localparam logic [3:0] S_WR     = 4'd4;
  localparam logic [3:0] S_CV_LD  = 4'd5;
  localparam logic [3:0] S_CV_IT  = 4'd6;
  localparam logic [3:0] S_CV_FIN = 4'd7;
  localparam logic [3:0] S_POSE   = 4'd8;
  localparam logic [3:0] S_P_FREE = 4'd9;
  localparam logic [3:0] S_P_RBT  = 4'd10;
  localparam logic [3:0] S_R_INIT = 4'd11;
  localparam logic [3:0] S_R_STEP = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  function automatic logic on_grid(coord_t c, coord_t r);
    on_grid = !c[COORD_W-1] && (c[COORD_W-2:0] < (COORD_W-1)'(GRID_WIDTH)) &&
              !r[COORD_W-1] && (r[COORD_W-2:0] < (COORD_W-1)'(GRID_HEIGHT));
  endfunction

  function automatic logic [AW-1:0] cell_addr(coord_t c, coord_t r);
    cell_addr = AW'(r[ROW_W-1:0]) * AW'(GRID_WIDTH) + AW'(c[COL_W-1:0]);
  endfunction

  function automatic coord_t ext16(logic [MM_W-1:0] v);
    ext16 = {{(COORD_W-MM_W){v[MM_W-1]}}, v};
  endfunction

  // configuration registers
  logic [SIZE_W-1:0]   cell_size_q;
  logic [ORIGIN_W-1:0] origin_col_q, origin_row_q;
  logic [CODE_W-1:0]   code_unknown_q, code_free_q, code_robot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q    <= SIZE_RST;
      origin_col_q   <= ORIGIN_RST;
      origin_row_q   <= ORIGIN_RST;
      code_unknown_q <= UNKNOWN_RST;
      code_free_q    <= FREE_RST;
      code_robot_q   <= ROBOT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELL_SIZE:  cell_size_q    <= cfg_data_i[SIZE_W-1:0];
        REG_ORIGIN_COL: origin_col_q   <= cfg_data_i[ORIGIN_W-1:0];
        REG_ORIGIN_ROW: origin_row_q   <= cfg_data_i[ORIGIN_W-1:0];
        REG_UNKNOWN:    code_unknown_q <= cfg_data_i[CODE_W-1:0];
        REG_FREE:       code_free_q    <= cfg_data_i[CODE_W-1:0];
        REG_ROBOT:      code_robot_q   <= cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // latched input item
  logic [IN_DATA_W-1:0] in_data_q;
  logic [2:0]           op_q;
  coord_t               cc, cr;
  logic [CODE_W-1:0]    wval;

  assign cc   = ext16(in_data_q[79:64]);
  assign cr   = ext16(in_data_q[95:80]);
  assign wval = in_data_q[103:96];

  // cell store
  logic [CODE_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CODE_W-1:0] mem_wdata;
  logic [CODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[cell_addr(cc, cr)];
  end

  // sequencer registers
  logic [3:0]          state_q, state_d;
  logic                rst_pass_q, rst_pass_d;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  logic                last_valid_q, last_valid_d;
  logic [COL_W-1:0]    last_col_q, last_col_d;
  logic [ROW_W-1:0]    last_row_q, last_row_d;
  logic [CODE_W-1:0]   done_val_q, done_val_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [1:0]          conv_idx_q, conv_idx_d;
  logic [CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [SIZE_W:0]     rem_q, rem_d;
  logic                neg_q, neg_d;
  coord_t              conv_q [4];
  logic                conv_we;
  coord_t              conv_res;
  coord_t              x_q, x_d, y_q, y_d;
  err_t                err_q, err_d, dx_q, dx_d, dy_q, dy_d;
  logic                stx_neg_q, stx_neg_d, sty_neg_q, sty_neg_d;

  // output register
  logic                out_valid_q;
  logic                out_kind_q, out_last_q;
  logic [OUT_COORD_W-1:0] out_col_q, out_row_q;
  logic [CODE_W-1:0]   out_value_q;
  logic [STATUS_W-1:0] out_status_q;

  logic                can_emit, emit, e_kind;
  logic [OUT_COORD_W-1:0] e_col, e_row;
  logic [CODE_W-1:0]   e_val;
  logic [STATUS_W-1:0] e_status;

  assign can_emit = !out_valid_q || m_axis_tready;

  // divider operand selection
  logic [MM_W-1:0]     mm_sel;
  logic [ORIGIN_W-1:0] org_sel;
  logic signed [MM_W:0] mm_ext, mm_abs;
  logic [SIZE_W-1:0]   c_eff;
  logic [SIZE_W:0]     div_d;
  logic [SIZE_W+1:0]   rem_sh;

  always_comb begin
    case (conv_idx_q)
      2'd0:    mm_sel = in_data_q[15:0];
      2'd1:    mm_sel = in_data_q[31:16];
      2'd2:    mm_sel = in_data_q[47:32];
      default: mm_sel = in_data_q[63:48];
    endcase
    org_sel = conv_idx_q[0] ? origin_row_q : origin_col_q;
    mm_ext  = {mm_sel[MM_W-1], mm_sel};
    mm_abs  = mm_ext[MM_W] ? -mm_ext : mm_ext;
    c_eff   = (cell_size_q == '0) ? SIZE_W'(1) : cell_size_q;
    div_d   = {c_eff, 1'b0};
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    conv_res = neg_q ? COORD_W'(org_sel) - COORD_W'(num_q)
                     : COORD_W'(org_sel) + COORD_W'(num_q);
  end

  // ray stepping
  coord_t x1, y1, nx, ny;
  logic signed [ERR_W:0] e2;
  logic step_x, step_y;
  err_t err_n;

  always_comb begin
    x1     = conv_q[2];
    y1     = conv_q[3];
    e2     = {err_q, 1'b0};
    step_x = e2 >= (ERR_W+1)'(dy_q);
    step_y = e2 <= (ERR_W+1)'(dx_q);
    err_n  = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
    nx     = x_q + (step_x ? (stx_neg_q ? -COORD_W'(1) : COORD_W'(1)) : '0);
    ny     = y_q + (step_y ? (sty_neg_q ? -COORD_W'(1) : COORD_W'(1)) : '0);
  end

  always_comb begin
    state_d      = state_q;
    rst_pass_d   = rst_pass_q;
    clr_addr_d   = clr_addr_q;
    last_valid_d = last_valid_q;
    last_col_d   = last_col_q;
    last_row_d   = last_row_q;
    done_val_d   = done_val_q;
    status_d     = status_q;
    conv_idx_d   = conv_idx_q;
    div_cnt_d    = div_cnt_q;
    num_d        = num_q;
    rem_d        = rem_q;
    neg_d        = neg_q;
    conv_we      = 1'b0;
    x_d          = x_q;
    y_d          = y_q;
    err_d        = err_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    stx_neg_d    = stx_neg_q;
    sty_neg_d    = sty_neg_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_q;
    mem_wdata    = code_free_q;
    emit         = 1'b0;
    e_kind       = KIND_CELL;
    e_col        = '0;
    e_row        = '0;
    e_val        = '0;
    e_status     = ST_OK;
    s_axis_tready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          done_val_d = '0;
          status_d   = ST_OK;
          conv_idx_d = '0;
          unique case (s_axis_tuser)
            OP_CLEAR: begin
              last_valid_d = 1'b0;
              clr_addr_d   = '0;
              state_d      = S_CLEAR;
            end
            OP_READ:             state_d = S_RD;
            OP_WRITE:            state_d = S_WR;
            OP_POSE, OP_RAY:     state_d = S_CV_LD;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = rst_pass_q ? UNKNOWN_RST : code_unknown_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d    = rst_pass_q ? S_IDLE : S_DONE;
          rst_pass_d = 1'b0;
        end
      end
      S_RD:  state_d = S_RD2;
      S_RD2: begin
        done_val_d = on_grid(cc, cr) ? rdata_q : code_unknown_q;
        state_d    = S_DONE;
      end
      S_WR: begin
        if (!on_grid(cc, cr)) begin
          state_d = S_DONE;
        end else if (can_emit) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(cc, cr);
          mem_wdata = wval;
          emit      = 1'b1;
          e_col     = OUT_COORD_W'(cc[COL_W-1:0]);
          e_row     = OUT_COORD_W'(cr[ROW_W-1:0]);
          e_val     = wval;
          state_d   = S_DONE;
        end
      end
      S_CV_LD: begin
        neg_d     = mm_ext[MM_W];
        num_d     = NUM_W'({mm_abs, 1'b0}) + NUM_W'(c_eff);
        rem_d     = '0;
        div_cnt_d = '0;
        state_d   = S_CV_IT;
      end
      S_CV_IT: begin
        // one restoring step: the numerator register fills with quotient bits
        if (rem_sh >= (SIZE_W+2)'(div_d)) begin
          rem_d = (SIZE_W+1)'(rem_sh - (SIZE_W+2)'(div_d));
          num_d = {num_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[SIZE_W:0];
          num_d = {num_q[NUM_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + CNT_W'(1);
        if (div_cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = S_CV_FIN;
        end
      end
      S_CV_FIN: begin
        conv_we    = 1'b1;
        conv_idx_d = conv_idx_q + 2'd1;
        if (op_q == OP_POSE && conv_idx_q == 2'd1) begin
          state_d = S_POSE;
        end else if (conv_idx_q == 2'd3) begin
          state_d = S_R_INIT;
        end else begin
          state_d = S_CV_LD;
        end
      end
      S_POSE: begin
        if (!on_grid(conv_q[0], conv_q[1])) begin
          status_d = ST_OFF_MAP;
          state_d  = S_DONE;
        end else if (last_valid_q && conv_q[0][COL_W-1:0] == last_col_q &&
                     conv_q[1][ROW_W-1:0] == last_row_q) begin
          status_d = ST_SAME;
          state_d  = S_DONE;
        end else begin
          state_d = last_valid_q ? S_P_FREE : S_P_RBT;
        end
      end
      S_P_FREE: begin
        if (can_emit) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(last_row_q) * AW'(GRID_WIDTH) + AW'(last_col_q);
          mem_wdata = code_free_q;
          emit      = 1'b1;
          e_col     = OUT_COORD_W'(last_col_q);
          e_row     = OUT_COORD_W'(last_row_q);
          e_val     = code_free_q;
          state_d   = S_P_RBT;
        end
      end
      S_P_RBT: begin
        if (can_emit) begin
          mem_we       = 1'b1;
          mem_waddr    = cell_addr(conv_q[0], conv_q[1]);
          mem_wdata    = code_robot_q;
          emit         = 1'b1;
          e_col        = OUT_COORD_W'(conv_q[0][COL_W-1:0]);
          e_row        = OUT_COORD_W'(conv_q[1][ROW_W-1:0]);
          e_val        = code_robot_q;
          last_col_d   = conv_q[0][COL_W-1:0];
          last_row_d   = conv_q[1][ROW_W-1:0];
          last_valid_d = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_R_INIT: begin
        x_d       = conv_q[0];
        y_d       = conv_q[1];
        dx_d      = (x1 > conv_q[0]) ? ERR_W'(x1 - conv_q[0]) : ERR_W'(conv_q[0] - x1);
        dy_d      = (y1 > conv_q[1]) ? ERR_W'(conv_q[1] - y1) : ERR_W'(y1 - conv_q[1]);
        stx_neg_d = !(conv_q[0] < x1);
        sty_neg_d = !(conv_q[1] < y1);
        err_d     = ((x1 > conv_q[0]) ? ERR_W'(x1 - conv_q[0]) : ERR_W'(conv_q[0] - x1)) +
                    ((y1 > conv_q[1]) ? ERR_W'(conv_q[1] - y1) : ERR_W'(y1 - conv_q[1]));
        state_d   = S_R_STEP;
      end
      S_R_STEP: begin
        if ((x_q == x1 && y_q == y1) || (nx == x1 && ny == y1)) begin
          state_d = S_DONE;
        end else if (!on_grid(nx, ny)) begin
          x_d   = nx;
          y_d   = ny;
          err_d = err_n;
        end else if (can_emit) begin
          x_d       = nx;
          y_d       = ny;
          err_d     = err_n;
          mem_we    = 1'b1;
          mem_waddr = cell_addr(nx, ny);
          mem_wdata = code_free_q;
          emit      = 1'b1;
          e_col     = OUT_COORD_W'(nx[COL_W-1:0]);
          e_row     = OUT_COORD_W'(ny[ROW_W-1:0]);
          e_val     = code_free_q;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_kind   = KIND_DONE;
          e_val    = done_val_q;
          e_status = status_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      rst_pass_q   <= 1'b1;
      clr_addr_q   <= '0;
      last_valid_q <= 1'b0;
      last_col_q   <= '0;
      last_row_q   <= '0;
      conv_idx_q   <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rst_pass_q   <= rst_pass_d;
      clr_addr_q   <= clr_addr_d;
      last_valid_q <= last_valid_d;
      last_col_q   <= last_col_d;
      last_row_q   <= last_row_d;
      conv_idx_q   <= conv_idx_d;
      div_cnt_q    <= div_cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      op_q      <= s_axis_tuser;
    end
    if (conv_we) begin
      conv_q[conv_idx_q] <= conv_res;
    end
    done_val_q <= done_val_d;
    status_q   <= status_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    x_q        <= x_d;
    y_q        <= y_d;
    err_q      <= err_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    stx_neg_q  <= stx_neg_d;
    sty_neg_q  <= sty_neg_d;
    if (emit) begin
      out_kind_q   <= e_kind;
      out_last_q   <= e_kind;
      out_col_q    <= e_col;
      out_row_q    <= e_row;
      out_value_q  <= e_val;
      out_status_q <= e_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, out_status_q, out_value_q, out_row_q, out_col_q};

`ifndef SYNTHESIS
  // no store writes while waiting for an operation
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("cell store written while idle");

  // a done transfer is loaded only on the way back to idle
  a_done_ends_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && e_kind == KIND_DONE) |=> (state_q == S_IDLE))
    else $error("done emitted without returning to idle");

  // the reset sweep never overlaps an accepted transfer
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_pass_q |-> !s_axis_tready)
    else $error("input accepted during reset sweep");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import ogru_pkg::*;

  localparam int GW = 32;
  localparam int GH = 32;
  localparam int CYCLE_LIMIT = 4000000;

  // one expected result transfer on m_axis
  typedef struct {
    bit       kind;
    bit [4:0] col;
    bit [4:0] row;
    bit [7:0] value;
    bit [1:0] status;
    bit       last;
  } grid_result_t;

  // grid predictor plus queue of expected results
  class grid_scoreboard;
    bit [11:0]    cell_size;
    bit [4:0]     org_col, org_row;
    byte          code_unk, code_free, code_robot;
    byte          cells[GW*GH];
    bit           held_valid;
    int           held_col, held_row;
    grid_result_t pending[$];
    int           errors;

    function void reset_state();
      cell_size = SIZE_RST; org_col = ORIGIN_RST; org_row = ORIGIN_RST;
      code_unk = UNKNOWN_RST; code_free = FREE_RST; code_robot = ROBOT_RST;
      foreach (cells[i]) cells[i] = code_unk;
      held_valid = 0; held_col = 0; held_row = 0;
      errors = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [11:0] data);
      case (idx)
        REG_CELL_SIZE:  cell_size = data;
        REG_ORIGIN_COL: org_col = data[4:0];
        REG_ORIGIN_ROW: org_row = data[4:0];
        REG_UNKNOWN:    code_unk = data[7:0];
        REG_FREE:       code_free = data[7:0];
        REG_ROBOT:      code_robot = data[7:0];
        default: ;
      endcase
    endfunction

    // round half away from zero; a zero size acts as one
    function longint to_cell(shortint mm, bit [4:0] origin);
      longint c, a, q;
      c = (cell_size == 0) ? 1 : cell_size;
      a = (mm < 0) ? -longint'(mm) : longint'(mm);
      q = (2 * a + c) / (2 * c);
      if (mm < 0) q = -q;
      return q + origin;
    endfunction

    function bit in_grid(longint c, longint r);
      return c >= 0 && c < GW && r >= 0 && r < GH;
    endfunction

    function void push(bit kind, bit [4:0] col, bit [4:0] row, byte v, bit [1:0] st,
                       bit last);
      grid_result_t e;
      e.kind = kind; e.col = col; e.row = row; e.value = v; e.status = st; e.last = last;
      pending.push_back(e);
    endfunction

    function void mark(longint c, longint r, byte v);
      if (!in_grid(c, r)) return;
      cells[r*GW + c] = v;
      push(KIND_CELL, c[4:0], r[4:0], v, ST_OK, 1'b0);
    endfunction

    function void note_op(bit [2:0] op, shortint sx, shortint sy, shortint ex,
                          shortint ey, shortint cc, shortint cr, byte wv);
      byte      done_val;
      bit [1:0] st;
      longint   gc, gr, x1, y1, dx, dy, stx, sty, err, e2, x, y;
      done_val = 0;
      st = ST_OK;
      case (op)
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = code_unk;
          held_valid = 0;
        end
        OP_READ: done_val = in_grid(cc, cr) ? cells[cr*GW + cc] : code_unk;
        OP_WRITE: mark(cc, cr, wv);
        OP_POSE: begin
          gc = to_cell(sx, org_col);
          gr = to_cell(sy, org_row);
          if (!in_grid(gc, gr)) st = ST_OFF_MAP;
          else if (held_valid && gc == held_col && gr == held_row) st = ST_SAME;
          else begin
            if (held_valid) mark(held_col, held_row, code_free);
            mark(gc, gr, code_robot);
            held_col = gc; held_row = gr; held_valid = 1;
          end
        end
        OP_RAY: begin
          x = to_cell(sx, org_col);
          y = to_cell(sy, org_row);
          x1 = to_cell(ex, org_col);
          y1 = to_cell(ey, org_row);
          dx = (x1 > x) ? x1 - x : x - x1;
          dy = -((y1 > y) ? y1 - y : y - y1);
          stx = (x < x1) ? 1 : -1;
          sty = (y < y1) ? 1 : -1;
          err = dx + dy;
          // end cell itself is never marked
          while (!(x == x1 && y == y1)) begin
            e2 = 2 * err;
            if (e2 >= dy) begin err += dy; x += stx; end
            if (e2 <= dx) begin err += dx; y += sty; end
            if (x == x1 && y == y1) break;
            mark(x, y, code_free);
          end
        end
        default: ;
      endcase
      push(KIND_DONE, 5'd0, 5'd0, done_val, st, 1'b1);
    endfunction

    function void check(bit kind, bit [23:0] d, bit last);
      grid_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: kind %0d data %h", kind, d);
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind || d[4:0] !== e.col || d[9:5] !== e.row ||
          d[17:10] !== e.value || d[19:18] !== e.status || d[23:20] !== 4'd0 ||
          last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kind %0d col %0d row %0d val %0d st %0d last %0d | got kind %0d col %0d row %0d val %0d st %0d last %0d pad %h",
                   e.kind, e.col, e.row, $signed(e.value), e.status, e.last,
                   kind, d[4:0], d[9:5], $signed(d[17:10]), d[19:18], last, d[23:20]);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [2:0]            s_axis_tuser;
  logic                  s_axis_tvalid, s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser, m_axis_tlast, m_axis_tvalid, m_axis_tready;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  occupancy_grid_ray_update_core #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  grid_scoreboard grid_sb = new();

  // sender and receiver idling knobs
  int  stall_pct;     // chance of tready low per cycle
  bit  send_gaps;     // bursts with gaps on the input side
  bit  hold_req;      // long receiver hold-off requested
  int  burst_left;
  int  cycle_count;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // run-length guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: every accepted transfer goes to the scoreboard
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      grid_sb.check(m_axis_tuser, m_axis_tdata, m_axis_tlast);

  // receiver back-pressure: random pattern, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 0;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // one operation transfer on s_axis, then maybe a gap
  task automatic send_op(bit [2:0] op, shortint sx, shortint sy, shortint ex, shortint ey,
                         shortint cc, shortint cr, byte wv);
    int gap;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {wv, cr, cc, ey, ex, sy, sx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    grid_sb.note_op(op, sx, sy, ex, ey, cc, cr, wv);
    if (send_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else burst_left--;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (grid_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // all six registers plus the out-of-range indexes, on back-to-back edges
  task automatic load_settings(bit [11:0] size, bit [4:0] oc, bit [4:0] orw,
                               byte unk, byte fr, byte rb);
    bit [11:0] vals[8];
    vals[0] = size;
    vals[1] = {7'($urandom_range(0, 127)), oc};
    vals[2] = {7'($urandom_range(0, 127)), orw};
    vals[3] = {4'($urandom_range(0, 15)), unk};
    vals[4] = {4'($urandom_range(0, 15)), fr};
    vals[5] = {4'($urandom_range(0, 15)), rb};
    vals[6] = 12'($urandom);
    vals[7] = 12'($urandom);
    repeat (20) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      grid_sb.write_reg(3'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // position near the grid for this cell size, or anywhere in range
  function automatic shortint pick_mm(bit wide);
    int span, v;
    if (wide) return shortint'($urandom);
    span = ((grid_sb.cell_size == 0) ? 1 : grid_sb.cell_size) * 20;
    v = $urandom_range(0, 2 * span) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return shortint'(v);
  endfunction

  function automatic shortint pick_cell();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return shortint'($urandom_range(0, GW - 1));
    if (k < 9) return shortint'($urandom_range(0, 40)) - shortint'(4);
    return shortint'($urandom);
  endfunction

  task automatic random_ops(int n, bit wide_ok, bit pause_mid);
    int  k;
    bit  wide;
    bit [2:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 4)       op = OP_CLEAR;
      else if (k < 19) op = OP_READ;
      else if (k < 34) op = OP_WRITE;
      else if (k < 60) op = OP_POSE;
      else if (k < 94) op = OP_RAY;
      else             op = 3'($urandom_range(5, 7));
      wide = wide_ok && ($urandom_range(0, 3) == 0);
      send_op(op, pick_mm(wide), pick_mm(wide), pick_mm(wide), pick_mm(wide),
              pick_cell(), pick_cell(), byte'($urandom));
      // sender waits for every outstanding result once
      if (pause_mid && i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    stall_pct     = 0;
    send_gaps     = 0;
    hold_req      = 0;
    burst_left    = 0;
    cycle_count   = 0;
    grid_sb.reset_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the clearing sweep after reset
    do @(posedge clk_i); while (!s_axis_tready);

    // directed, reset settings: 50 mm cells, origin 16/16
    stall_pct = 25;
    send_op(OP_READ, 0, 0, 0, 0, 16, 16, 0);
    send_op(OP_WRITE, 0, 0, 0, 0, 0, 0, -128);
    send_op(OP_WRITE, 0, 0, 0, 0, 31, 31, 127);
    send_op(OP_WRITE, 0, 0, 0, 0, -32768, 32767, 85);   // off grid, nothing stored
    send_op(OP_READ, 0, 0, 0, 0, 31, 31, 0);
    send_op(OP_READ, 0, 0, 0, 0, 32, 0, 0);             // off grid read
    send_op(OP_READ, 0, 0, 0, 0, 32767, -32768, 0);
    send_op(OP_POSE, 25, -25, 0, 0, 0, 0, 0);           // half rounds away from zero
    send_op(OP_POSE, 24, -24, 0, 0, 0, 0, 0);
    send_op(OP_POSE, 40, -30, 0, 0, 0, 0, 0);           // back to the cell of the first pose
    send_op(OP_POSE, 32767, 0, 0, 0, 0, 0, 0);          // off map
    send_op(OP_POSE, -32768, -32768, 0, 0, 0, 0, 0);
    send_op(OP_RAY, 0, 0, 0, 0, 0, 0, 0);               // zero-length ray
    send_op(OP_RAY, -1000, -1000, 500, 600, 0, 0, 0);   // starts off grid
    send_op(OP_RAY, 700, -700, -700, 700, 0, 0, 0);
    send_op(OP_RAY, -32768, 32767, 32767, -32768, 0, 0, 0);
    send_op(OP_RAY, 0, -750, 0, 750, 0, 0, 0);
    send_op(5, 1, 2, 3, 4, 5, 6, 7);
    send_op(6, -1, -1, -1, -1, -1, -1, -1);
    send_op(7, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0, 0, 17, 15, 0);
    send_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_POSE, 25, -25, 0, 0, 0, 0, 0);           // held cell forgotten by clear
    send_op(OP_READ, 0, 0, 0, 0, 31, 31, 0);
    drain();

    // zero cell size acts as one; extreme codes; origin at the corner
    send_gaps = 1;
    load_settings(12'd0, 5'd0, 5'd0, -128, 127, 0);
    send_op(OP_RAY, -32768, -32768, 32767, 32767, 0, 0, 0);   // one long sweep
    send_op(OP_RAY, 3, 40, 3, -40, 0, 0, 0);
    random_ops(40, 0, 0);

    // largest cell size, far origin; receiver holds off while items keep coming
    stall_pct = 0;
    send_gaps = 0;
    load_settings(12'd4095, 5'd31, 5'd31, 127, -128, -1);
    hold_req = 1;
    random_ops(40, 1, 0);

    // heavy stalls both sides, pause mid phase
    stall_pct = 60;
    send_gaps = 1;
    load_settings(12'd137, 5'd5, 5'd27, byte'($urandom), byte'($urandom), byte'($urandom));
    random_ops(40, 1, 1);

    // back to typical size with the reset codes
    stall_pct = 20;
    load_settings(12'd50, 5'd16, 5'd16, -1, 0, 2);
    random_ops(40, 1, 0);

    stall_pct = 40;
    load_settings(12'($urandom_range(20, 800)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)),
                  byte'($urandom), byte'($urandom), byte'($urandom));
    random_ops(40, 1, 0);

    repeat (50) @(posedge clk_i);
    if (grid_sb.errors == 0 && grid_sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
